@@ sv/pwts_pkg.sv @@
// Shared constants and types of the world-to-screen projection block.
package pwts_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROW_X_01 = 3'd0;
  localparam logic [2:0] REG_ROW_X_23 = 3'd1;
  localparam logic [2:0] REG_ROW_Y_01 = 3'd2;
  localparam logic [2:0] REG_ROW_Y_23 = 3'd3;
  localparam logic [2:0] REG_ROW_W_01 = 3'd4;
  localparam logic [2:0] REG_ROW_W_23 = 3'd5;
  localparam logic [2:0] REG_VIEWPORT = 3'd6;
  localparam logic [2:0] REG_W_MIN    = 3'd7;

  // Register widths and reset values.
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned VP_W     = 32;
  localparam int unsigned WMIN_W   = 31;
  localparam logic [VP_W-1:0]   VIEWPORT_RST = 32'h0438_0780;
  localparam logic [WMIN_W-1:0] W_MIN_RST    = 31'd6554;

  // Half of a 16-bit viewport dimension.
  localparam int unsigned HALF_W = 15;

  // Quotient bits resolved by the divider chain; larger quotients are capped.
  localparam int unsigned QB       = 21;
  localparam logic [QB-1:0] QUOT_CAP = 21'h10_0000;

  // Cycles from an accepted transaction to its result strobe.
  localparam int unsigned LATENCY = QB + 5;

  // Control flags that travel with each point down the pipeline.
  typedef struct packed {
    logic valid;
    logic visible;
    logic neg_x;
    logic neg_y;
    logic big_x;
    logic big_y;
  } ctl_t;

endpackage

@@ sv/pwts_row.sv @@
// One matrix row: three products, then the saturated clip sum.
module pwts_row #(
  parameter int unsigned POS_BITS  = 24,
  parameter int unsigned COEF_BITS = 32,
  parameter int unsigned CLIP_W    = 58
) (
  input  logic                       clk_i,
  input  logic signed [POS_BITS-1:0] pos_x_i,
  input  logic signed [POS_BITS-1:0] pos_y_i,
  input  logic signed [POS_BITS-1:0] pos_z_i,
  input  logic [63:0]                coef01_i,
  input  logic [63:0]                coef23_i,
  output logic signed [CLIP_W-1:0]   clip_o
);
  import pwts_pkg::*;

  localparam int unsigned PROD_W = POS_BITS + COEF_BITS;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic signed [COEF_BITS-1:0] c0, c1, c2, c3;
  logic signed [PROD_W-1:0]    px_q, py_q, pz_q;
  logic signed [COEF_BITS+7:0] c3_q;
  logic signed [SUM_W-1:0]     sum, lim_hi, lim_lo, sat;
  logic signed [CLIP_W-1:0]    clip_q;

  assign c0 = coef01_i[COEF_BITS-1:0];
  assign c1 = coef01_i[32+COEF_BITS-1:32];
  assign c2 = coef23_i[COEF_BITS-1:0];
  assign c3 = coef23_i[32+COEF_BITS-1:32];

  // Product stage.
  always_ff @(posedge clk_i) begin
    px_q <= pos_x_i * c0;
    py_q <= pos_y_i * c1;
    pz_q <= pos_z_i * c2;
    c3_q <= {c3, 8'h00};
  end

  // Sum stage, clamped to the clip range.
  assign sum = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q) + SUM_W'(c3_q);
  assign lim_hi = $signed({{(SUM_W-CLIP_W+1){1'b0}}, {(CLIP_W-1){1'b1}}});
  assign lim_lo = -lim_hi;

  always_comb begin
    sat = sum;
    if (sum > lim_hi) begin
      sat = lim_hi;
    end else if (sum < lim_lo) begin
      sat = lim_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    clip_q <= sat[CLIP_W-1:0];
  end

  assign clip_o = clip_q;

endmodule

@@ sv/pwts_div_cell.sv @@
// One divider cell: resolves one quotient bit for the x and y lanes.
module pwts_div_cell #(
  parameter int unsigned D_W = 57,
  parameter int unsigned N_W = 72,
  parameter int unsigned BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwts_pkg::ctl_t       ctl_i,
  input  logic [D_W-1:0]       d_i,
  input  logic [N_W-1:0]       rx_i,
  input  logic [N_W-1:0]       ry_i,
  input  logic [pwts_pkg::QB-1:0] qx_i,
  input  logic [pwts_pkg::QB-1:0] qy_i,
  output pwts_pkg::ctl_t       ctl_o,
  output logic [D_W-1:0]       d_o,
  output logic [N_W-1:0]       rx_o,
  output logic [N_W-1:0]       ry_o,
  output logic [pwts_pkg::QB-1:0] qx_o,
  output logic [pwts_pkg::QB-1:0] qy_o
);
  import pwts_pkg::*;

  localparam int unsigned CMP_W = N_W + QB;

  logic [CMP_W-1:0] dsh, dx, dy;
  logic             gex, gey;
  ctl_t             ctl_q;
  logic [D_W-1:0]   d_q;
  logic [N_W-1:0]   rx_q, ry_q;
  logic [QB-1:0]    qx_q, qy_q;

  // Trial subtraction of the shifted divisor in each lane.
  assign dsh = CMP_W'(d_i) << BIT;
  assign gex = CMP_W'(rx_i) >= dsh;
  assign gey = CMP_W'(ry_i) >= dsh;
  assign dx  = CMP_W'(rx_i) - dsh;
  assign dy  = CMP_W'(ry_i) - dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= d_i;
    rx_q <= gex ? dx[N_W-1:0] : rx_i;
    ry_q <= gey ? dy[N_W-1:0] : ry_i;
    qx_q <= qx_i | (QB'(gex) << BIT);
    qy_q <= qy_i | (QB'(gey) << BIT);
  end

  assign ctl_o = ctl_q;
  assign d_o   = d_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign qx_o  = qx_q;
  assign qy_o  = qy_q;

endmodule

@@ sv/perspective_world_to_screen.sv @@
// Top level of the world-to-screen projection pipeline.
//
// Usage: raise start_i for one cycle with a world position on pos_x_i,
// pos_y_i and pos_z_i (signed Q15.8). The transaction is accepted at that
// edge; busy_o stays low, so a new position may be given in every cycle.
// Each point is multiplied by three matrix rows, tested against the near
// limit and divided by clip w in a chain of one-bit divider cells.
// The result appears on visible_o, screen_x_o and screen_y_o for exactly one
// cycle, marked by done_o, after these registered steps in order: the matrix
// products, the matrix sums, scaling by the half viewport, the quotient range
// check, the QB divider cells (one quotient bit per cell) and the final offset
// and saturation. Throughput is one point per cycle. Results come out in
// acceptance order; the receiver cannot stall them. Configuration is written
// through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write it only
// while no transaction is in flight, as the block itself does not enforce
// this. Reset clears the pipeline valid flags, zeroes the matrix and restores
// the default viewport and near limit.
module perspective_world_to_screen #(
  parameter int unsigned COEF_BITS   = 32,
  parameter int unsigned POS_BITS    = 24,
  parameter int unsigned SCREEN_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [POS_BITS-1:0]    pos_x_i,
  input  logic signed [POS_BITS-1:0]    pos_y_i,
  input  logic signed [POS_BITS-1:0]    pos_z_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [pwts_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic                          visible_o,
  output logic signed [SCREEN_BITS-1:0] screen_x_o,
  output logic signed [SCREEN_BITS-1:0] screen_y_o
);
  import pwts_pkg::*;

  localparam int unsigned SUM_W  = POS_BITS + COEF_BITS + 2;
  localparam int unsigned CLIP_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int unsigned MAG_W  = CLIP_W - 1;
  localparam int unsigned N_W    = MAG_W + HALF_W;
  localparam int unsigned CMP_W  = N_W + QB;
  localparam int unsigned WC_W   = (CLIP_W > WMIN_W + 9) ? CLIP_W : WMIN_W + 9;
  localparam int unsigned V_W    = QB + 2;

  // Configuration registers.
  logic [CFG_W-1:0]  rx01_q, rx23_q, ry01_q, ry23_q, rw01_q, rw23_q;
  logic [VP_W-1:0]   vp_q;
  logic [WMIN_W-1:0] wmin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx01_q <= '0;
      rx23_q <= '0;
      ry01_q <= '0;
      ry23_q <= '0;
      rw01_q <= '0;
      rw23_q <= '0;
      vp_q   <= VIEWPORT_RST;
      wmin_q <= W_MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_X_01: rx01_q <= cfg_wdata_i;
        REG_ROW_X_23: rx23_q <= cfg_wdata_i;
        REG_ROW_Y_01: ry01_q <= cfg_wdata_i;
        REG_ROW_Y_23: ry23_q <= cfg_wdata_i;
        REG_ROW_W_01: rw01_q <= cfg_wdata_i;
        REG_ROW_W_23: rw23_q <= cfg_wdata_i;
        REG_VIEWPORT: vp_q   <= cfg_wdata_i[VP_W-1:0];
        REG_W_MIN:    wmin_q <= cfg_wdata_i[WMIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [HALF_W-1:0] half_w, half_h;
  assign half_w = vp_q[15:1];
  assign half_h = vp_q[31:17];

  // Matrix rows: products then clip sums.
  logic signed [CLIP_W-1:0] cx, cy, cw;

  pwts_row #(.POS_BITS(POS_BITS), .COEF_BITS(COEF_BITS), .CLIP_W(CLIP_W)) u_row_x (
    .clk_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .coef01_i(rx01_q), .coef23_i(rx23_q), .clip_o(cx)
  );
  pwts_row #(.POS_BITS(POS_BITS), .COEF_BITS(COEF_BITS), .CLIP_W(CLIP_W)) u_row_y (
    .clk_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .coef01_i(ry01_q), .coef23_i(ry23_q), .clip_o(cy)
  );
  pwts_row #(.POS_BITS(POS_BITS), .COEF_BITS(COEF_BITS), .CLIP_W(CLIP_W)) u_row_w (
    .clk_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .coef01_i(rw01_q), .coef23_i(rw23_q), .clip_o(cw)
  );

  // Valid flags for the two row stages.
  logic v1_q, v2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  // Near-limit test, magnitudes and scaling by the half viewport.
  logic                    vis;
  logic [CLIP_W-1:0]       ax, ay;
  logic signed [WC_W-1:0]  cw_ext, wlim;
  ctl_t                    c3_q;
  logic [N_W-1:0]          nx_q, ny_q;
  logic [MAG_W-1:0]        d3_q;

  assign cw_ext = WC_W'(cw);
  assign wlim   = $signed(WC_W'({wmin_q, 8'h00}));
  assign vis    = (cw > 0) && (cw_ext >= wlim);
  assign ax     = cx[CLIP_W-1] ? CLIP_W'(-cx) : CLIP_W'(cx);
  assign ay     = cy[CLIP_W-1] ? CLIP_W'(-cy) : CLIP_W'(cy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
    end else begin
      c3_q <= '{valid: v2_q, visible: vis, neg_x: cx[CLIP_W-1],
                neg_y: cy[CLIP_W-1], big_x: 1'b0, big_y: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= N_W'(ax[MAG_W-1:0]) * N_W'(half_w);
    ny_q <= N_W'(ay[MAG_W-1:0]) * N_W'(half_h);
    d3_q <= cw[MAG_W-1:0];
  end

  // Quotient range check: quotients of 2^QB or more are capped.
  ctl_t             ctl_c [QB+1];
  logic [MAG_W-1:0] d_c   [QB+1];
  logic [N_W-1:0]   rx_c  [QB+1];
  logic [N_W-1:0]   ry_c  [QB+1];
  logic [QB-1:0]    qx_c  [QB+1];
  logic [QB-1:0]    qy_c  [QB+1];
  logic [CMP_W-1:0] dtop;
  ctl_t             ctl0_d;

  assign dtop = CMP_W'(d3_q) << QB;

  always_comb begin
    ctl0_d       = c3_q;
    ctl0_d.big_x = CMP_W'(nx_q) >= dtop;
    ctl0_d.big_y = CMP_W'(ny_q) >= dtop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c[0] <= '0;
    end else begin
      ctl_c[0] <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_c[0]  <= d3_q;
    rx_c[0] <= nx_q;
    ry_c[0] <= ny_q;
    qx_c[0] <= '0;
    qy_c[0] <= '0;
  end

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < QB; k++) begin : g_cell
    pwts_div_cell #(.D_W(MAG_W), .N_W(N_W), .BIT(QB - 1 - k)) u_cell (
      .clk_i, .rst_ni,
      .ctl_i(ctl_c[k]), .d_i(d_c[k]), .rx_i(rx_c[k]), .ry_i(ry_c[k]),
      .qx_i(qx_c[k]), .qy_i(qy_c[k]),
      .ctl_o(ctl_c[k+1]), .d_o(d_c[k+1]), .rx_o(rx_c[k+1]), .ry_o(ry_c[k+1]),
      .qx_o(qx_c[k+1]), .qy_o(qy_c[k+1])
    );
  end

  // Cap, sign, offset by the half viewport and saturate.
  ctl_t                    ce;
  logic [QB-1:0]           qx, qy;
  logic signed [V_W-1:0]   vx, vy, slim_hi, slim_lo, sx, sy;

  assign ce = ctl_c[QB];
  assign qx = (ce.big_x || (qx_c[QB] > QUOT_CAP)) ? QUOT_CAP : qx_c[QB];
  assign qy = (ce.big_y || (qy_c[QB] > QUOT_CAP)) ? QUOT_CAP : qy_c[QB];
  assign vx = $signed(V_W'(half_w)) + (ce.neg_x ? -$signed(V_W'(qx)) : $signed(V_W'(qx)));
  assign vy = $signed(V_W'(half_h)) + (ce.neg_y ? $signed(V_W'(qy)) : -$signed(V_W'(qy)));
  assign slim_hi = $signed({{(V_W-SCREEN_BITS+1){1'b0}}, {(SCREEN_BITS-1){1'b1}}});
  assign slim_lo = -slim_hi - V_W'(1);

  always_comb begin
    sx = vx;
    if (vx > slim_hi) begin
      sx = slim_hi;
    end else if (vx < slim_lo) begin
      sx = slim_lo;
    end
    sy = vy;
    if (vy > slim_hi) begin
      sy = slim_hi;
    end else if (vy < slim_lo) begin
      sy = slim_lo;
    end
  end

  logic                          done_q, vis_q;
  logic signed [SCREEN_BITS-1:0] sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ce.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q <= ce.visible;
    sx_q  <= ce.visible ? sx[SCREEN_BITS-1:0] : '0;
    sy_q  <= ce.visible ? sy[SCREEN_BITS-1:0] : '0;
  end

  assign busy_o     = 1'b0;
  assign done_o     = done_q;
  assign visible_o  = vis_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;

endmodule

@@ sv/pwts_chk.sv @@
// Port-level checker for the projection block, bound to the top level.
module pwts_chk #(
  parameter int unsigned SCREEN_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic                          visible_o,
  input logic signed [SCREEN_BITS-1:0] screen_x_o,
  input logic signed [SCREEN_BITS-1:0] screen_y_o
);
  import pwts_pkg::*;

  // Every accepted transaction yields a result after the fixed latency.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("result missing after accepted transaction");

  // No result appears without a transaction accepted before it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##LATENCY !done_o)
    else $error("result without a matching transaction");

  // A point that is not visible reports the origin.
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !visible_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("hidden point with non-zero screen position");

  // The pipeline never refuses a transaction.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind perspective_world_to_screen pwts_chk #(.SCREEN_BITS(SCREEN_BITS)) u_pwts_chk (.*);

@@ test/perspective_world_to_screen_tb.sv @@
// Self-checking testbench for the world-to-screen projection pipeline.
module perspective_world_to_screen_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwts_pkg::*;

  localparam int unsigned DRAIN_CYCLES = LATENCY + 10;
  localparam int unsigned STALL_LIMIT  = 2000;

  // One projected point.
  typedef struct packed {
    logic               visible;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } pixel_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [23:0] pos_x_i = '0;
  logic signed [23:0] pos_y_i = '0;
  logic signed [23:0] pos_z_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               done_o;
  logic               visible_o;
  logic signed [15:0] screen_x_o;
  logic signed [15:0] screen_y_o;

  // Shadow copy of the configuration.
  logic [63:0] mat_rows [6];
  logic [31:0] vp_size;
  logic [30:0] near_lim;

  pixel_t pending_pixels [$];
  int     mismatches = 0;
  int     idle_cycles = 0;

  perspective_world_to_screen DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on cycles without any accepted transaction or result strobe.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("perspective_world_to_screen: mismatch");
      $finish;
    end
  end

  // Saturating addition to +-(2^63-1).
  function automatic longint clip_add(longint a, longint b);
    longint cmax;
    cmax = 64'sh7fff_ffff_ffff_ffff;
    if (b > 0 && a > cmax - b) return cmax;
    if (b < 0 && a < -cmax - b) return -cmax;
    return a + b;
  endfunction

  function automatic longint row_dot(logic [63:0] r01, logic [63:0] r23,
                                     longint px, longint py, longint pz);
    longint acc;
    acc = clip_add(px * longint'($signed(r01[31:0])),
                   py * longint'($signed(r01[63:32])));
    acc = clip_add(acc, pz * longint'($signed(r23[31:0])));
    return clip_add(acc, longint'($signed(r23[63:32])) * 256);
  endfunction

  // Offset of the viewport centre by half * c / w, with the quotient capped, then saturate.
  function automatic logic signed [15:0] map_axis(longint half, longint c,
                                                  longint w, bit flip);
    logic [127:0] num, q;
    logic [63:0]  mag;
    longint       v;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    num = 128'(mag) * 128'(half);
    q = num / 128'(w);
    if (q > 128'(QUOT_CAP)) q = 128'(QUOT_CAP);
    v = longint'(q[63:0]);
    if ((c < 0) != flip) v = -v;
    v = half + v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic pixel_t project_point(logic [23:0] x, logic [23:0] y,
                                           logic [23:0] z);
    longint cx, cy, cw, px, py, pz;
    pixel_t r;
    px = longint'($signed(x));
    py = longint'($signed(y));
    pz = longint'($signed(z));
    cx = row_dot(mat_rows[0], mat_rows[1], px, py, pz);
    cy = row_dot(mat_rows[2], mat_rows[3], px, py, pz);
    cw = row_dot(mat_rows[4], mat_rows[5], px, py, pz);
    r = '0;
    if (cw <= 0 || cw < (longint'(near_lim) <<< 8)) return r;
    r.visible = 1'b1;
    r.sx = map_axis(longint'(vp_size[15:1]), cx, cw, 1'b0);
    r.sy = map_axis(longint'(vp_size[31:17]), cy, cw, 1'b1);
    return r;
  endfunction

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (done_o) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        exp_px = pending_pixels.pop_front();
        if (exp_px.visible !== visible_o || exp_px.sx !== screen_x_o ||
            exp_px.sy !== screen_y_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected vis=%0d x=%0d y=%0d, got vis=%0d x=%0d y=%0d",
                     exp_px.visible, exp_px.sx, exp_px.sy,
                     visible_o, screen_x_o, screen_y_o);
        end
      end
    end
  end

  // Sender gap: mostly none or short, occasionally long. Start drops only
  // when a gap follows, so back-to-back points keep it high.
  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Send one point and wait for the edge that accepts it.
  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    start_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    pending_pixels.push_back(project_point(x, y, z));
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    start_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx <= REG_ROW_W_23) mat_rows[idx] = val;
    else if (idx == REG_VIEWPORT) vp_size = val[31:0];
    else near_lim = val[30:0];
  endtask

  function automatic logic [63:0] coef_pair(int lo, int hi);
    return {32'(hi), 32'(lo)};
  endfunction

  // Random coefficient, mostly moderate, sometimes any 32-bit value.
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 262143)) - 131072);
  endfunction

  // Random world coordinate, mostly near the origin.
  function automatic logic [23:0] rand_pos();
    if ($urandom_range(0, 7) == 0) return 24'($urandom());
    return 24'($signed($urandom_range(0, 16383)) - 8192);
  endfunction

  // Matrix with a perspective-like w row so that most points are visible.
  task automatic load_camera();
    write_reg(REG_ROW_X_01, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_X_23, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_Y_01, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_Y_23, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_W_01, coef_pair($signed($urandom_range(0, 8191)) - 4096,
                                      $signed($urandom_range(0, 8191)) - 4096));
    write_reg(REG_ROW_W_23, coef_pair($urandom_range(32768, 131072),
                                      $urandom_range(0, 65536 * 200)));
  endtask

  // Directed points: field extremes, near-limit cases and huge quotients.
  task automatic test_directed();
    write_reg(REG_ROW_X_01, coef_pair(65536, 0));
    write_reg(REG_ROW_X_23, coef_pair(0, 0));
    write_reg(REG_ROW_Y_01, coef_pair(0, 65536));
    write_reg(REG_ROW_Y_23, coef_pair(0, 0));
    write_reg(REG_ROW_W_01, coef_pair(0, 0));
    write_reg(REG_ROW_W_23, coef_pair(65536, 0));
    send_point(24'h000000, 24'h000000, 24'h000100);
    send_point(24'h7fffff, 24'h800000, 24'h000100);
    send_point(24'h000100, 24'hffff00, 24'h7fffff);
    send_point(24'h000000, 24'h000000, 24'h800000);
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h000010, 24'h000010, 24'h000001);
    send_point(24'h7fffff, 24'h7fffff, 24'h000001);
    send_point(24'hffffff, 24'hffffff, 24'hffffff);
    send_point(24'h000000, 24'h000000, 24'h00001a);
    send_point(24'h000000, 24'h000000, 24'h000019);
    drain();
    // Zero near limit: w of zero is still rejected.
    write_reg(REG_W_MIN, 64'd0);
    send_point(24'h000100, 24'h000100, 24'h000000);
    send_point(24'h000100, 24'h000100, 24'h000001);
    // Extreme coefficients and extreme positions.
    drain();
    write_reg(REG_ROW_X_01, 64'h8000_0000_7fff_ffff);
    write_reg(REG_ROW_Y_01, 64'h7fff_ffff_8000_0000);
    write_reg(REG_ROW_W_23, 64'h7fff_ffff_7fff_ffff);
    send_point(24'h7fffff, 24'h800000, 24'h7fffff);
    send_point(24'h800000, 24'h7fffff, 24'h800000);
    drain();
  endtask

  // Random points over several camera and viewport settings.
  task automatic test_random_points(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 75 == 0) begin
        drain();
        load_camera();
        case ((i / 75) % 4)
          0: write_reg(REG_VIEWPORT, 64'(VIEWPORT_RST));
          1: write_reg(REG_VIEWPORT, 64'hffff_ffff);
          2: write_reg(REG_VIEWPORT, 64'h0000_0001);
          default: write_reg(REG_VIEWPORT, 64'($urandom()));
        endcase
        case ((i / 75) % 3)
          0: write_reg(REG_W_MIN, 64'(W_MIN_RST));
          1: write_reg(REG_W_MIN, 64'h7fff_ffff);
          default: write_reg(REG_W_MIN, 64'($urandom_range(0, 65536)));
        endcase
      end
      send_point(rand_pos(), rand_pos(), rand_pos());
      sender_gap();
    end
  endtask

  initial begin
    mat_rows = '{default: '0};
    vp_size  = VIEWPORT_RST;
    near_lim = W_MIN_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_points(450);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("perspective_world_to_screen: match");
    else
      $display("perspective_world_to_screen: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
sv/pwts_pkg.sv
sv/pwts_row.sv
sv/pwts_div_cell.sv
sv/perspective_world_to_screen.sv
sv/pwts_chk.sv
test/perspective_world_to_screen_tb.sv
